@@ hw/rtl/hts_pkg.sv @@
`default_nettype none

package hts_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;

    localparam int IDX_W   = $clog2(MAX_STATES);
    localparam int COUNT_W = IDX_W + 1;
    localparam int DRAW_W  = 32;
    localparam int PROB_W  = 33;
    localparam int SEL_W   = 2;
    localparam int ADDR_W  = SEL_W + 2 * IDX_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;
    localparam int UPC_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int NCH_W   = 2;

    localparam logic [PROB_W-1:0] Q_ONE = {1'b1, {(PROB_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_LOAD    = 2'd2
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        TS_INIT   = 2'd0,
        TS_TRANS  = 2'd1,
        TS_EMIT_A = 2'd2,
        TS_EMIT_B = 2'd3
    } tbl_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_STATES    = 2'd0,
        CFG_NUM_SYMBOLS_A = 2'd1,
        CFG_NUM_SYMBOLS_B = 2'd2,
        CFG_NUM_CHANNELS  = 2'd3
    } cfg_idx_t;

    // micro-op kinds
    typedef enum logic [1:0] {
        K_WAIT  = 2'd0,
        K_SETUP = 2'd1,
        K_WALK  = 2'd2,
        K_PUSH  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CH_STATE = 2'd0,
        CH_A     = 2'd1,
        CH_B     = 2'd2
    } chan_t;

    // branch conditions on the emission channel count
    typedef enum logic [1:0] {
        SK_NONE     = 2'd0,
        SK_NO_EMIT  = 2'd1,
        SK_ONE_EMIT = 2'd2
    } skip_t;

    typedef struct packed {
        kind_t            kind;
        chan_t            chan;
        skip_t            skip;
        logic [UPC_W-1:0] next_upc;
        logic [UPC_W-1:0] skip_upc;
    } ucode_t;

    localparam logic [UPC_W-1:0] UA_WAIT    = 3'd0;
    localparam logic [UPC_W-1:0] UA_SETUP_S = 3'd1;
    localparam logic [UPC_W-1:0] UA_WALK_S  = 3'd2;
    localparam logic [UPC_W-1:0] UA_SETUP_A = 3'd3;
    localparam logic [UPC_W-1:0] UA_WALK_A  = 3'd4;
    localparam logic [UPC_W-1:0] UA_SETUP_B = 3'd5;
    localparam logic [UPC_W-1:0] UA_WALK_B  = 3'd6;
    localparam logic [UPC_W-1:0] UA_PUSH    = 3'd7;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        unique case (upc)
            UA_WAIT:    w = '{K_WAIT,  CH_STATE, SK_NONE,     UA_SETUP_S, UA_SETUP_S};
            UA_SETUP_S: w = '{K_SETUP, CH_STATE, SK_NONE,     UA_WALK_S,  UA_WALK_S};
            UA_WALK_S:  w = '{K_WALK,  CH_STATE, SK_NO_EMIT,  UA_SETUP_A, UA_PUSH};
            UA_SETUP_A: w = '{K_SETUP, CH_A,     SK_NONE,     UA_WALK_A,  UA_WALK_A};
            UA_WALK_A:  w = '{K_WALK,  CH_A,     SK_ONE_EMIT, UA_SETUP_B, UA_PUSH};
            UA_SETUP_B: w = '{K_SETUP, CH_B,     SK_NONE,     UA_WALK_B,  UA_WALK_B};
            UA_WALK_B:  w = '{K_WALK,  CH_B,     SK_NONE,     UA_PUSH,    UA_PUSH};
            UA_PUSH:    w = '{K_PUSH,  CH_STATE, SK_NONE,     UA_WAIT,    UA_WAIT};
            default:    w = '{K_WAIT,  CH_STATE, SK_NONE,     UA_WAIT,    UA_WAIT};
        endcase
        return w;
    endfunction

    // last index in use, count saturated to 1..max_cnt
    function automatic logic [IDX_W-1:0] last_index(input logic [COUNT_W-1:0] n,
                                                    input int max_cnt);
        logic [COUNT_W-1:0] m;
        if (n == '0)
            m = '0;
        else if (n > COUNT_W'(max_cnt))
            m = COUNT_W'(max_cnt - 1);
        else
            m = n - COUNT_W'(1);
        return m[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hmm_trajectory_sampler.sv @@
`default_nettype none

// channel | handshake             | payload
// --------+-----------------------+-----------------------------------------------
// in      | in_valid / in_stall   | cmd, draw_state, draw_emit_a, draw_emit_b,
//         |                       | table_sel, row_index, col_index, prob_word
// out     | out_valid / out_stall | hidden_state, symbol_a, symbol_b, fell_through
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Restart and load words never raise in_stall and give no result.
// A step word walks the cumulative sum with one table read per cycle, up to
// 16 reads each for the state and both emission channels, plus a setup step per
// walk and a final step that places the result, which waits on a stalled output.
// Reset clears the chain, current state and output valid and presets registers;
// tables hold garbage until loaded. in_stall stays high while a step is in progress
// and while the finished result waits for a stalled output register.

module hmm_trajectory_sampler
    import hts_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,

    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  [1:0]            cmd,
    input  wire  [DRAW_W-1:0]     draw_state,
    input  wire  [DRAW_W-1:0]     draw_emit_a,
    input  wire  [DRAW_W-1:0]     draw_emit_b,
    input  wire  [SEL_W-1:0]      table_sel,
    input  wire  [IDX_W-1:0]      row_index,
    input  wire  [IDX_W-1:0]      col_index,
    input  wire  [PROB_W-1:0]     prob_word,

    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [IDX_W-1:0]      hidden_state,
    output logic [IDX_W-1:0]      symbol_a,
    output logic [IDX_W-1:0]      symbol_b,
    output logic                  fell_through,

    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    // ---------------------------------------------------------------------
    // Configuration registers, stored raw and saturated where used
    // ---------------------------------------------------------------------
    logic [COUNT_W-1:0] num_states_reg;
    logic [COUNT_W-1:0] num_sym_a_reg;
    logic [COUNT_W-1:0] num_sym_b_reg;
    logic [NCH_W-1:0]   num_ch_reg;
    logic [NCH_W-1:0]   nch_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= COUNT_W'(MAX_STATES);
            num_sym_a_reg  <= COUNT_W'(MAX_SYMBOLS);
            num_sym_b_reg  <= COUNT_W'(MAX_SYMBOLS);
            num_ch_reg     <= NCH_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_STATES:    num_states_reg <= cfg_data[COUNT_W-1:0];
                CFG_NUM_SYMBOLS_A: num_sym_a_reg  <= cfg_data[COUNT_W-1:0];
                CFG_NUM_SYMBOLS_B: num_sym_b_reg  <= cfg_data[COUNT_W-1:0];
                CFG_NUM_CHANNELS:  num_ch_reg     <= cfg_data[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // at most two emission channels
    assign nch_eff = (num_ch_reg > NCH_W'(2)) ? NCH_W'(2) : num_ch_reg;

    // ---------------------------------------------------------------------
    // Sequencer: program counter into the microcode table
    // ---------------------------------------------------------------------
    logic [UPC_W-1:0] upc_reg, upc_next;
    ucode_t           uw;
    logic             in_acc;
    cmd_t             in_cmd;
    logic             advance;
    logic             skip_true;
    logic             walk_done;
    logic             slot_free;

    assign uw       = ucode_rom(upc_reg);
    assign in_stall = (uw.kind != K_WAIT);
    assign in_acc   = in_valid && !in_stall;
    assign in_cmd   = cmd_t'(cmd);

    // output register is free next cycle if empty or being taken now
    assign slot_free = !out_valid || !out_stall;

    always_comb
    begin
        unique case (uw.kind)
            K_WAIT:  advance = in_acc && (in_cmd == CMD_STEP);
            K_SETUP: advance = 1'b1;
            K_WALK:  advance = walk_done;
            K_PUSH:  advance = slot_free;
            default: advance = 1'b0;
        endcase

        unique case (uw.skip)
            SK_NO_EMIT:  skip_true = (nch_eff == '0);
            SK_ONE_EMIT: skip_true = (nch_eff < NCH_W'(2));
            default:     skip_true = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (advance)
            upc_next = skip_true ? uw.skip_upc : uw.next_upc;
    end

    // ---------------------------------------------------------------------
    // Datapath: one saturating accumulator walked over a table row
    // ---------------------------------------------------------------------
    logic               started_reg,  started_next;
    logic [IDX_W-1:0]   cur_reg,      cur_next;
    logic [DRAW_W-1:0]  draw_s_reg,   draw_s_next;
    logic [DRAW_W-1:0]  draw_a_reg,   draw_a_next;
    logic [DRAW_W-1:0]  draw_b_reg,   draw_b_next;
    logic [DRAW_W-1:0]  draw_reg,     draw_next;
    logic [PROB_W-1:0]  sum_reg,      sum_next;
    logic [IDX_W-1:0]   idx_reg,      idx_next;
    logic [IDX_W-1:0]   last_reg,     last_next;
    tbl_sel_t           tbl_reg,      tbl_next;
    logic [IDX_W-1:0]   row_reg,      row_next;
    logic [IDX_W-1:0]   sym_a_reg,    sym_a_next;
    logic [IDX_W-1:0]   sym_b_reg,    sym_b_next;
    logic               miss_reg,     miss_next;
    logic [PROB_W-1:0]  rd_data_reg;

    logic [PROB_W:0]    sum_add;
    logic [PROB_W-1:0]  sum_sat;
    logic               hit;

    // saturate at 1.0 so oversized entries count as 1.0
    assign sum_add   = {1'b0, sum_reg} + {1'b0, rd_data_reg};
    assign sum_sat   = (sum_add > {1'b0, Q_ONE}) ? Q_ONE : sum_add[PROB_W-1:0];
    assign hit       = (sum_sat >= {1'b0, draw_reg});
    assign walk_done = hit || (idx_reg == last_reg);

    always_comb
    begin
        started_next = started_reg;
        cur_next     = cur_reg;
        draw_s_next  = draw_s_reg;
        draw_a_next  = draw_a_reg;
        draw_b_next  = draw_b_reg;
        draw_next    = draw_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        tbl_next     = tbl_reg;
        row_next     = row_reg;
        sym_a_next   = sym_a_reg;
        sym_b_next   = sym_b_reg;
        miss_next    = miss_reg;

        unique case (uw.kind)
            K_WAIT:
            begin
                if (in_acc)
                begin
                    case (in_cmd)
                        CMD_RESTART: started_next = 1'b0;
                        CMD_STEP:
                        begin
                            draw_s_next = draw_state;
                            draw_a_next = draw_emit_a;
                            draw_b_next = draw_emit_b;
                            sym_a_next  = '0;
                            sym_b_next  = '0;
                            miss_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            K_SETUP:
            begin
                sum_next = '0;
                idx_next = '0;
                case (uw.chan)
                    CH_A:
                    begin
                        tbl_next  = TS_EMIT_A;
                        row_next  = cur_reg;
                        draw_next = draw_a_reg;
                        last_next = last_index(num_sym_a_reg, MAX_SYMBOLS);
                    end
                    CH_B:
                    begin
                        tbl_next  = TS_EMIT_B;
                        row_next  = cur_reg;
                        draw_next = draw_b_reg;
                        last_next = last_index(num_sym_b_reg, MAX_SYMBOLS);
                    end
                    default:
                    begin
                        // first step after restart uses the initial table
                        tbl_next  = started_reg ? TS_TRANS : TS_INIT;
                        row_next  = started_reg ? cur_reg : '0;
                        draw_next = draw_s_reg;
                        last_next = last_index(num_states_reg, MAX_STATES);
                    end
                endcase
            end
            K_WALK:
            begin
                if (walk_done)
                begin
                    miss_next = miss_reg | !hit;
                    case (uw.chan)
                        CH_A: sym_a_next = idx_reg;
                        CH_B: sym_b_next = idx_reg;
                        default:
                        begin
                            cur_next     = idx_reg;
                            started_next = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    sum_next = sum_sat;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= UA_WAIT;
            started_reg <= 1'b0;
            cur_reg     <= '0;
        end
        else
        begin
            upc_reg     <= upc_next;
            started_reg <= started_next;
            cur_reg     <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_s_reg <= draw_s_next;
        draw_a_reg <= draw_a_next;
        draw_b_reg <= draw_b_next;
        draw_reg   <= draw_next;
        sum_reg    <= sum_next;
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        tbl_reg    <= tbl_next;
        row_reg    <= row_next;
        sym_a_reg  <= sym_a_next;
        sym_b_reg  <= sym_b_next;
        miss_reg   <= miss_next;
    end

    // ---------------------------------------------------------------------
    // Probability store: {table, row, column}; initial table lives in row 0
    // ---------------------------------------------------------------------
    logic [PROB_W-1:0] tbl_mem [TBL_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    assign mem_we    = in_acc && (in_cmd == CMD_LOAD);
    assign mem_waddr = {table_sel,
                        (tbl_sel_t'(table_sel) == TS_INIT) ? IDX_W'(0) : row_index,
                        col_index};
    // address from next-cycle values so data lines up with idx_reg
    assign mem_raddr = {tbl_next, row_next, idx_next};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tbl_mem[mem_waddr] <= prob_word;
        rd_data_reg <= tbl_mem[mem_raddr];
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    logic             out_valid_reg, out_valid_next;
    logic             push;
    logic [IDX_W-1:0] o_state_reg;
    logic [IDX_W-1:0] o_sym_a_reg;
    logic [IDX_W-1:0] o_sym_b_reg;
    logic             o_miss_reg;

    assign push = (uw.kind == K_PUSH) && slot_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            o_state_reg <= cur_reg;
            o_sym_a_reg <= sym_a_reg;
            o_sym_b_reg <= sym_b_reg;
            o_miss_reg  <= miss_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hidden_state = o_state_reg;
    assign symbol_a     = o_sym_a_reg;
    assign symbol_b     = o_sym_b_reg;
    assign fell_through = o_miss_reg;

endmodule

`default_nettype wire

@@ tb/tb_hmm_trajectory_sampler.sv @@
module tb_hmm_trajectory_sampler;
    import hts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cmd 3 has no meaning; the block must drop such a word silently
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int          RESET_CYCLES = 9;
    // a step walks at most 3 x 16 entries plus setup and push, which the drain covers
    localparam int          DRAIN_CYCLES = 64;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          NUM_PHASES   = 7;
    localparam int          PHASE_WORDS  = 60;
    localparam int          HOLD_AFTER   = 20;
    localparam int unsigned CYCLE_LIMIT  = 1_200_000;
    localparam int          MAX_REPORTS  = 10;

    // one input word, field for field as on the ports
    typedef struct packed {
        logic [1:0]        op;
        logic [DRAW_W-1:0] ds;
        logic [DRAW_W-1:0] da;
        logic [DRAW_W-1:0] db;
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROB_W-1:0] prob;
    } in_word_t;

    // one sampled time step
    typedef struct packed {
        logic [IDX_W-1:0] hs;
        logic [IDX_W-1:0] sa;
        logic [IDX_W-1:0] sb;
        logic             ft;
    } sample_t;

    // directed row: a word, plus a hand-written sample where one is obvious
    typedef struct packed {
        in_word_t w;
        logic     typed;
        sample_t  s;
    } dir_row_t;

    localparam sample_t NO_SAMPLE = '0;

    logic clk = 1'b0;
    logic rst_n;

    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            cmd;
    logic [DRAW_W-1:0]     draw_state;
    logic [DRAW_W-1:0]     draw_emit_a;
    logic [DRAW_W-1:0]     draw_emit_b;
    logic [SEL_W-1:0]      table_sel;
    logic [IDX_W-1:0]      row_index;
    logic [IDX_W-1:0]      col_index;
    logic [PROB_W-1:0]     prob_word;

    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_W-1:0]      hidden_state;
    logic [IDX_W-1:0]      symbol_a;
    logic [IDX_W-1:0]      symbol_b;
    logic                  fell_through;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hmm_trajectory_sampler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .draw_state   (draw_state),
        .draw_emit_a  (draw_emit_a),
        .draw_emit_b  (draw_emit_b),
        .table_sel    (table_sel),
        .row_index    (row_index),
        .col_index    (col_index),
        .prob_word    (prob_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hidden_state (hidden_state),
        .symbol_a     (symbol_a),
        .symbol_b     (symbol_b),
        .fell_through (fell_through),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Chain model: own copy of the tables, the chain and the registers
    // ------------------------------------------------------------------
    logic [PROB_W-1:0] init_tbl   [MAX_STATES];
    logic [PROB_W-1:0] trans_tbl  [MAX_STATES][MAX_STATES];
    logic [PROB_W-1:0] emit_a_tbl [MAX_STATES][MAX_SYMBOLS];
    logic [PROB_W-1:0] emit_b_tbl [MAX_STATES][MAX_SYMBOLS];
    logic [IDX_W-1:0]  chain_state = '0;
    logic              chain_live  = 1'b0;

    logic [CFG_DATA_W-1:0] cfg_states   = 5'd16;
    logic [CFG_DATA_W-1:0] cfg_syms_a   = 5'd16;
    logic [CFG_DATA_W-1:0] cfg_syms_b   = 5'd16;
    logic [NCH_W-1:0]      cfg_channels = 2'd1;

    // samples still to come out of the block, oldest first
    sample_t expected_samples [$];

    int  mismatch_count = 0;
    bit  calm           = 1'b0;   // no idling on either side
    bit  tx_quiet       = 1'b0;
    bit  rx_quiet       = 1'b0;
    bit  hold_req       = 1'b0;   // asks the receiver for one long hold-off
    bit  in_held        = 1'b0;   // in_valid is (or is about to be) high

    int unsigned cycle_count = 0;

    function automatic int clamp_count(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    // inverse CDF over the first n entries of a row, sum saturating at 1.0
    function automatic logic [IDX_W-1:0] cdf_pick(input tbl_sel_t sel,
                                                 input logic [IDX_W-1:0] row,
                                                 input int n,
                                                 input logic [DRAW_W-1:0] draw,
                                                 output bit missed);
        logic [PROB_W:0]   acc;
        logic [PROB_W-1:0] w;
        int                i;
        acc    = '0;
        missed = 1'b0;
        for (i = 0; i < n; i++)
        begin
            case (sel)
                TS_INIT:   w = init_tbl[i];
                TS_TRANS:  w = trans_tbl[row][i];
                TS_EMIT_A: w = emit_a_tbl[row][i];
                default:   w = emit_b_tbl[row][i];
            endcase
            acc = acc + {1'b0, w};
            if (acc > {1'b0, Q_ONE})
                acc = {1'b0, Q_ONE};
            if (acc >= {2'b00, draw})
                return IDX_W'(i);
        end
        missed = 1'b1;
        return IDX_W'(n - 1);
    endfunction

    // applies one accepted word; returns 1 when it yields a sample
    function automatic bit advance_chain(input in_word_t w, output sample_t s);
        bit miss_s;
        bit miss_a;
        bit miss_b;
        int ns;
        int nch;
        s      = '0;
        miss_a = 1'b0;
        miss_b = 1'b0;
        case (w.op)
            CMD_RESTART:
            begin
                chain_live = 1'b0;
                return 1'b0;
            end
            CMD_LOAD:
            begin
                case (w.sel)
                    TS_INIT:   init_tbl[w.col] = w.prob;   // row ignored
                    TS_TRANS:  trans_tbl[w.row][w.col] = w.prob;
                    TS_EMIT_A: emit_a_tbl[w.row][w.col] = w.prob;
                    default:   emit_b_tbl[w.row][w.col] = w.prob;
                endcase
                return 1'b0;
            end
            CMD_STEP:
            begin
                ns  = clamp_count(cfg_states, MAX_STATES);
                nch = (cfg_channels > 2'd2) ? 2 : int'(cfg_channels);
                if (!chain_live)
                    s.hs = cdf_pick(TS_INIT, '0, ns, w.ds, miss_s);
                else
                    s.hs = cdf_pick(TS_TRANS, chain_state, ns, w.ds, miss_s);
                chain_state = s.hs;
                chain_live  = 1'b1;
                if (nch >= 1)
                    s.sa = cdf_pick(TS_EMIT_A, s.hs, clamp_count(cfg_syms_a, MAX_SYMBOLS),
                                    w.da, miss_a);
                if (nch == 2)
                    s.sb = cdf_pick(TS_EMIT_B, s.hs, clamp_count(cfg_syms_b, MAX_SYMBOLS),
                                    w.db, miss_b);
                s.ft = miss_s | miss_a | miss_b;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic in_word_t make_word(input logic [1:0] op,
                                           input logic [DRAW_W-1:0] ds,
                                           input logic [DRAW_W-1:0] da,
                                           input logic [DRAW_W-1:0] db,
                                           input logic [SEL_W-1:0] sel,
                                           input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col,
                                           input logic [PROB_W-1:0] prob);
        in_word_t w;
        w.op   = op;
        w.ds   = ds;
        w.da   = da;
        w.db   = db;
        w.sel  = sel;
        w.row  = row;
        w.col  = col;
        w.prob = prob;
        return w;
    endfunction

    function automatic sample_t smp(input int hs, input int sa, input int sb, input int ft);
        sample_t s;
        s.hs = IDX_W'(hs);
        s.sa = IDX_W'(sa);
        s.sb = IDX_W'(sb);
        s.ft = ft[0];
        return s;
    endfunction

    // uniform draw with the two ends weighted up
    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return Q_ONE;
            2:       return {1'b0, {DRAW_W{1'b1}}};
            default: return {1'b0, $urandom()};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one word, holding it steady until the block takes it, then
    // runs it through the model. A typed sample overrides the model's.
    task automatic offer_word(input in_word_t w, input bit typed, input sample_t typed_s);
        sample_t s;
        int      gap;
        if (!calm && !tx_quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            if (in_held)
                in_valid <= 1'b0;
            in_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_held     = 1'b1;
        cmd         <= w.op;
        draw_state  <= w.ds;
        draw_emit_a <= w.da;
        draw_emit_b <= w.db;
        table_sel   <= w.sel;
        row_index   <= w.row;
        col_index   <= w.col;
        prob_word   <= w.prob;
        do
            @(posedge clk);
        while (in_stall);
        if (advance_chain(w, s))
            expected_samples.push_back(typed ? typed_s : s);
    endtask

    // Rewrites a whole row. Non-zero rows each get their own scale, so some rows
    // saturate within a few entries and others run out before the draw.
    task automatic load_row(input tbl_sel_t sel, input logic [IDX_W-1:0] row, input bit zeros);
        logic [PROB_W-1:0] p;
        int                sh;
        int                c;
        sh = $urandom_range(0, 5);
        for (c = 0; c < MAX_SYMBOLS; c++)
        begin
            if (zeros)
                p = '0;
            else if ($urandom_range(0, 31) == 0)
                p = Q_ONE;
            else
                p = {1'b0, $urandom()} >> sh;
            offer_word(make_word(CMD_LOAD, $urandom(), $urandom(), $urandom(), sel,
                                 (sel == TS_INIT) ? IDX_W'($urandom()) : row,
                                 IDX_W'(c), p), 1'b0, '0);
        end
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic configure(input logic [CFG_DATA_W-1:0] ns, input logic [CFG_DATA_W-1:0] na,
                             input logic [CFG_DATA_W-1:0] nb, input logic [CFG_DATA_W-1:0] nc);
        logic [CFG_DATA_W-1:0] vals [4];
        int                    i;
        vals[0] = ns;
        vals[1] = na;
        vals[2] = nb;
        vals[3] = nc;
        if (in_held)
            in_valid <= 1'b0;
        in_held = 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        for (i = 0; i < 4; i++)
        begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (cfg_idx_t'(i))
                CFG_NUM_STATES:    cfg_states   = vals[i];
                CFG_NUM_SYMBOLS_A: cfg_syms_a   = vals[i];
                CFG_NUM_SYMBOLS_B: cfg_syms_b   = vals[i];
                CFG_NUM_CHANNELS:  cfg_channels = vals[i][NCH_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t              directed [$];
        logic [CFG_DATA_W-1:0] phase_cfg [NUM_PHASES][4];
        int                    ph;
        int                    words;
        int                    pick;
        int                    i;
        int                    r;
        bit                    hold_done;

        hold_done   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_RESTART;
        draw_state  = '0;
        draw_emit_a = '0;
        draw_emit_b = '0;
        table_sel   = TS_INIT;
        row_index   = '0;
        col_index   = '0;
        prob_word   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NUM_STATES;
        cfg_data    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tables are undefined after reset, so every entry is written
        // before any step can read it. Zeros make the directed rows obvious.
        load_row(TS_INIT, '0, 1'b1);
        for (r = 0; r < MAX_STATES; r++)
        begin
            load_row(TS_TRANS, IDX_W'(r), 1'b1);
            load_row(TS_EMIT_A, IDX_W'(r), 1'b1);
            load_row(TS_EMIT_B, IDX_W'(r), 1'b1);
        end

        // Directed rows, reset registers: 16 states, channel a only.
        // first step draws from the initial table; zero sums still reach a zero draw
        directed.push_back({make_word(CMD_STEP, '0, '0, '1, TS_INIT, '0, '0, '0),
                            1'b1, smp(0, 0, 0, 0)});
        // all-zero transition row never reaches the top draw: last state, flag
        directed.push_back({make_word(CMD_STEP, '1, '0, '0, TS_INIT, '0, '0, '0),
                            1'b1, smp(15, 0, 0, 1)});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_TRANS, 4'd15, 4'd3, Q_ONE),
                            1'b0, NO_SAMPLE});
        // a full 1.0 entry meets every draw; empty emission row falls through
        directed.push_back({make_word(CMD_STEP, '1, '1, '0, TS_INIT, '0, '0, '0),
                            1'b1, smp(3, 15, 0, 1)});
        // unused command, everything high: must be dropped
        directed.push_back({make_word(CMD_UNUSED, '1, '1, '1, TS_EMIT_B, '1, '1, Q_ONE),
                            1'b0, NO_SAMPLE});
        // chain carries on from state 3 as if nothing came in between
        directed.push_back({make_word(CMD_STEP, 32'd1, '0, '0, TS_INIT, '0, '0, '0),
                            1'b1, smp(15, 0, 0, 1)});
        directed.push_back({make_word(CMD_RESTART, '1, '1, '1, TS_EMIT_B, '1, '1, Q_ONE),
                            1'b0, NO_SAMPLE});
        // initial table ignores the row index
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_INIT, 4'd15, 4'd7, Q_ONE),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_STEP, '1, '0, '0, TS_INIT, '0, '0, '0),
                            1'b1, smp(7, 0, 0, 0)});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_EMIT_A, 4'd7, 4'd0,
                                      {1'b0, {DRAW_W{1'b1}}}), 1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_EMIT_A, 4'd7, 4'd1, 33'd1),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_RESTART, '0, '0, '0, TS_INIT, '0, '0, '0),
                            1'b0, NO_SAMPLE});
        // restart sends the chain back to the initial table; b stays at zero
        directed.push_back({make_word(CMD_STEP, '1, '1, '1, TS_INIT, '0, '0, '0),
                            1'b1, smp(7, 0, 0, 0)});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_EMIT_B, 4'd7, 4'd15, Q_ONE),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_LOAD, '1, '1, '1, TS_EMIT_B, 4'd0, 4'd0, '0),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_TRANS, 4'd7, 4'd0,
                                      33'h0_8000_0000), 1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_TRANS, 4'd7, 4'd1, Q_ONE),
                            1'b0, NO_SAMPLE});
        // half plus a full entry: cumulative sum has to saturate
        directed.push_back({make_word(CMD_STEP, 32'h8000_0001, 32'h1234_5678, '1,
                                      TS_INIT, '0, '0, '0), 1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_STEP, 32'h8000_0000, '0, '0, TS_INIT, '0, '0, '0),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_LOAD, '0, '0, '0, TS_INIT, 4'd0, 4'd0, Q_ONE),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_RESTART, '0, '0, '0, TS_INIT, '0, '0, '0),
                            1'b0, NO_SAMPLE});
        directed.push_back({make_word(CMD_STEP, '0, '1, '0, TS_INIT, '0, '0, '0),
                            1'b0, NO_SAMPLE});

        for (i = 0; i < directed.size(); i++)
            offer_word(directed[i].w, directed[i].typed, directed[i].s);

        // Register settings per phase: extremes, out-of-range values
        // (saturated by the block), a mid setting and a random one.
        phase_cfg[0] = '{5'd16, 5'd16, 5'd16, 5'd2};
        phase_cfg[1] = '{5'd1,  5'd1,  5'd1,  5'd2};
        phase_cfg[2] = '{5'd0,  5'd0,  5'd0,  5'd0};
        phase_cfg[3] = '{5'd31, 5'd17, 5'd31, 5'd31};
        phase_cfg[4] = '{5'd4,  5'd9,  5'd2,  5'd1};
        phase_cfg[5] = '{5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                         5'($urandom_range(1, 16)), 5'($urandom_range(0, 2))};
        phase_cfg[6] = '{5'd16, 5'd16, 5'd16, 5'd2};

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
            calm = (ph == NUM_PHASES - 1);

            // first phase refills every table with proper distributions
            if (ph == 0)
            begin
                load_row(TS_INIT, '0, 1'b0);
                for (r = 0; r < MAX_STATES; r++)
                begin
                    load_row(TS_TRANS, IDX_W'(r), 1'b0);
                    load_row(TS_EMIT_A, IDX_W'(r), 1'b0);
                    load_row(TS_EMIT_B, IDX_W'(r), 1'b0);
                end
            end

            words = 0;
            while (words < PHASE_WORDS)
            begin
                if (words % 40 == 0)
                    tx_quiet = ($urandom_range(0, 2) == 0);
                // receiver sits on its stall while steps keep coming
                if (ph == 0 && !hold_done && words >= HOLD_AFTER)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    load_row(tbl_sel_t'($urandom_range(0, 3)), IDX_W'($urandom()), 1'b0);
                    words += MAX_SYMBOLS;
                end
                else if (pick < 11)
                begin
                    offer_word(make_word(CMD_LOAD, $urandom(), $urandom(), $urandom(),
                                         SEL_W'($urandom()), IDX_W'($urandom()),
                                         IDX_W'($urandom()), rand_prob()), 1'b0, '0);
                    words++;
                end
                else if (pick < 16)
                begin
                    offer_word(make_word(CMD_RESTART, $urandom(), $urandom(), $urandom(),
                                         SEL_W'($urandom()), IDX_W'($urandom()),
                                         IDX_W'($urandom()), rand_prob()), 1'b0, '0);
                    words++;
                end
                else if (pick < 19)
                begin
                    // noise: dropped by the block, not counted
                    offer_word(make_word(CMD_UNUSED, $urandom(), $urandom(), $urandom(),
                                         SEL_W'($urandom()), IDX_W'($urandom()),
                                         IDX_W'($urandom()), rand_prob()), 1'b0, '0);
                end
                else
                begin
                    offer_word(make_word(CMD_STEP, rand_draw(), rand_draw(), rand_draw(),
                                         SEL_W'($urandom()), IDX_W'($urandom()),
                                         IDX_W'($urandom()), rand_prob()), 1'b0, '0);
                    words++;
                end
            end
        end

        if (in_held)
            in_valid <= 1'b0;
        in_held = 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("tb_hmm_trajectory_sampler OK");
        else
            $display("tb_hmm_trajectory_sampler NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts, quiet stretches, one long hold
    // ------------------------------------------------------------------
    initial
    begin : stall_gen
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 99) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    // ------------------------------------------------------------------
    // Sample check: every sample taken against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_check
        sample_t got;
        sample_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {hidden_state, symbol_a, symbol_b, fell_through};
            if (expected_samples.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected sample: state %h a %h b %h fell %b",
                             got.hs, got.sa, got.sb, got.ft);
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("sample mismatch: exp state %h a %h b %h fell %b, got state %h a %h b %h fell %b",
                                 want.hs, want.sa, want.sb, want.ft,
                                 got.hs, got.sa, got.sb, got.ft);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_hmm_trajectory_sampler NOT OK");
            $finish;
        end
    end

endmodule
